### sv/sit_pkg.sv
package sit_pkg;

    // default coordinate width, bits per field
    localparam int COORD_BITS_DEF = 16;

endpackage

### sv/sit_seg_if.sv
interface sit_seg_if #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
);

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid,
        output a_start_x, a_start_y, a_end_x, a_end_y,
        output b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  a_start_x, a_start_y, a_end_x, a_end_y,
        input  b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );

endinterface

### sv/sit_res_if.sv
interface sit_res_if;

    logic valid;
    logic ready;
    logic intersects;

    modport source (
        output valid,
        output intersects,
        input  ready
    );

    modport sink (
        input  valid,
        input  intersects,
        output ready
    );

endinterface

### sv/segment_intersection_test.sv
// Segment intersection test. Each word on i_seg carries two segments, A and B, as
// signed COORD_BITS-bit integer coordinates; one word on o_res answers whether they
// intersect, counting collinear or parallel straddling as a hit and a shared endpoint
// alone as a miss. While the output is not stalled the block takes one word per
// clock: an accepted word is captured in the input register, the four orientation
// tests and the direction determinant are worked out in parallel from that
// register, and the answer is registered in the result register, which drives
// o_res.valid. Both registers move independently, so a new word is taken while a
// finished answer still waits on o_res.ready; i_seg.ready falls only when both are
// full and the output is stalled.
module segment_intersection_test #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sit_seg_if.sink  i_seg,
    sit_res_if.source o_res
);

    localparam int D = COORD_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic signed [COORD_BITS-1:0] x3;
        logic signed [COORD_BITS-1:0] y3;
        logic signed [COORD_BITS-1:0] x4;
        logic signed [COORD_BITS-1:0] y4;
    } t_seg;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_turn;

    function automatic logic signed [D-1:0] f_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        f_diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    function automatic t_turn f_turn(
        input logic signed [COORD_BITS-1:0] x1,
        input logic signed [COORD_BITS-1:0] y1,
        input logic signed [COORD_BITS-1:0] x2,
        input logic signed [COORD_BITS-1:0] y2,
        input logic signed [COORD_BITS-1:0] x3,
        input logic signed [COORD_BITS-1:0] y3
    );
        logic signed [D-1:0]   ux;
        logic signed [D-1:0]   uy;
        logic signed [D-1:0]   vx;
        logic signed [D-1:0]   vy;
        logic signed [2*D-1:0] l;
        logic signed [2*D-1:0] r;
        logic signed [2*D:0]   su;
        logic signed [2*D:0]   sv;
        logic                  opp;
        t_turn                 t;
        ux  = f_diff(x2, x1);
        uy  = f_diff(y2, y1);
        vx  = f_diff(x3, x1);
        vy  = f_diff(y3, y1);
        l   = (2*D)'(ux) * (2*D)'(vy);
        r   = (2*D)'(uy) * (2*D)'(vx);
        su  = (2*D+1)'(ux) * (2*D+1)'(ux) + (2*D+1)'(uy) * (2*D+1)'(uy);
        sv  = (2*D+1)'(vx) * (2*D+1)'(vx) + (2*D+1)'(vy) * (2*D+1)'(vy);
        // collinear point lying behind the base point
        opp = (ux[D-1] && !vx[D-1] && vx != '0) || (vx[D-1] && !ux[D-1] && ux != '0) ||
              (uy[D-1] && !vy[D-1] && vy != '0) || (vy[D-1] && !uy[D-1] && uy != '0);
        if (l > r) begin
            t = '{pos: 1'b1, neg: 1'b0};
        end else if (l < r) begin
            t = '{pos: 1'b0, neg: 1'b1};
        end else if (opp) begin
            t = '{pos: 1'b0, neg: 1'b1};
        end else if (su >= sv) begin
            t = '{pos: 1'b0, neg: 1'b0};
        end else begin
            t = '{pos: 1'b1, neg: 1'b0};
        end
        f_turn = t;
    endfunction

    logic                r_s1_vld;
    t_seg                r_s1;
    logic                r_out_vld;
    logic                r_out_hit;

    logic                s1_adv;
    logic                s2_adv;
    t_turn               turn_a3;
    t_turn               turn_a4;
    t_turn               turn_b1;
    t_turn               turn_b2;
    logic                straddle;
    logic signed [2*D-1:0] p_a;
    logic signed [2*D-1:0] p_b;
    logic signed [2*D:0]   det;
    logic                touch;
    logic                n_out_hit;

    assign s2_adv      = !r_out_vld || o_res.ready;
    assign s1_adv      = !r_s1_vld || s2_adv;
    assign i_seg.ready = s1_adv;

    always_comb begin
        turn_a3 = f_turn(r_s1.x1, r_s1.y1, r_s1.x2, r_s1.y2, r_s1.x3, r_s1.y3);
        turn_a4 = f_turn(r_s1.x1, r_s1.y1, r_s1.x2, r_s1.y2, r_s1.x4, r_s1.y4);
        turn_b1 = f_turn(r_s1.x3, r_s1.y3, r_s1.x4, r_s1.y4, r_s1.x1, r_s1.y1);
        turn_b2 = f_turn(r_s1.x3, r_s1.y3, r_s1.x4, r_s1.y4, r_s1.x2, r_s1.y2);
        // product of two turns is positive only when both agree in sign
        straddle = !((turn_a3.pos && turn_a4.pos) || (turn_a3.neg && turn_a4.neg)) &&
                   !((turn_b1.pos && turn_b2.pos) || (turn_b1.neg && turn_b2.neg));
        // det regrouped as (x3-x4)(y1-y2) + (x2-x1)(y3-y4)
        p_a = (2*D)'(f_diff(r_s1.x3, r_s1.x4)) * (2*D)'(f_diff(r_s1.y1, r_s1.y2));
        p_b = (2*D)'(f_diff(r_s1.x2, r_s1.x1)) * (2*D)'(f_diff(r_s1.y3, r_s1.y4));
        det = (2*D+1)'(p_a) + (2*D+1)'(p_b);
        touch = (r_s1.x1 == r_s1.x3 && r_s1.y1 == r_s1.y3) ||
                (r_s1.x1 == r_s1.x4 && r_s1.y1 == r_s1.y4) ||
                (r_s1.x2 == r_s1.x3 && r_s1.y2 == r_s1.y3) ||
                (r_s1.x2 == r_s1.x4 && r_s1.y2 == r_s1.y4);
        n_out_hit = straddle && ((det == '0) || !touch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= i_seg.valid;
            end
            if (s2_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_seg.valid) begin
            r_s1.x1 <= i_seg.a_start_x;
            r_s1.y1 <= i_seg.a_start_y;
            r_s1.x2 <= i_seg.a_end_x;
            r_s1.y2 <= i_seg.a_end_y;
            r_s1.x3 <= i_seg.b_start_x;
            r_s1.y3 <= i_seg.b_start_y;
            r_s1.x4 <= i_seg.b_end_x;
            r_s1.y4 <= i_seg.b_end_y;
        end
        if (s2_adv && r_s1_vld) begin
            r_out_hit <= n_out_hit;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.intersects = r_out_hit;

`ifndef SYNTHESIS
    a_accept_fills_s1 : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> r_s1_vld
    ) else $error("accepted word not held in input register");

    a_s1_moves_to_out : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && s2_adv) |=> o_res.valid
    ) else $error("input register advanced without a result");

    a_s1_holds_on_stall : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s2_adv) |=> (r_s1_vld && $stable(r_s1))
    ) else $error("input register changed while stalled");

    a_ready_only_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_seg.ready |-> (r_s1_vld && o_res.valid && !o_res.ready)
    ) else $error("ready dropped with room in the pipeline");
`endif

endmodule
